>>> rtl/ptu_pkg.sv
// ----------------------------------------------------------------------------
// ptu_pkg
// Types, codes and saturation helpers shared by the particle table blocks.
// ----------------------------------------------------------------------------
package ptu_pkg;

  // width of the live particle count
  localparam int unsigned CntW = 7;

  // input operation codes
  localparam logic OP_SPAWN = 1'b0;
  localparam logic OP_TICK  = 1'b1;

  // configuration register indexes
  localparam logic CFG_GRAVITY = 1'b0;
  localparam logic CFG_LAUNCH  = 1'b1;

  // result status codes
  typedef enum logic [1:0] {
    ST_SPAWNED = 2'd0,
    ST_FULL    = 2'd1,
    ST_REPORT  = 2'd2,
    ST_EMPTY   = 2'd3
  } status_e;

  // sequencer states
  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_UPD   = 4'b0010,
    S_REP   = 4'b0100,
    S_NONE  = 4'b1000
  } state_e;

  // one table entry as held in memory
  typedef struct packed {
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic signed [31:0] speed_y;
    logic        [23:0] age;
    logic        [23:0] life;
    logic        [15:0] size;
  } entry_t;

  // updated entry leaving the integrator
  typedef struct packed {
    logic   vld;
    entry_t entry;
  } upd_t;

  // clamp a 33-bit signed value to 32 bits
  function automatic logic signed [31:0] sat33(input logic signed [32:0] v);
    logic signed [31:0] r;
    if (v[32] != v[31]) begin
      r = v[32] ? 32'sh8000_0000 : 32'sh7fff_ffff;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

  // clamp a 34-bit signed value to 32 bits
  function automatic logic signed [31:0] sat34(input logic signed [33:0] v);
    logic signed [31:0] r;
    if ((v[33] != v[32]) || (v[33] != v[31])) begin
      r = v[33] ? 32'sh8000_0000 : 32'sh7fff_ffff;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage

>>> rtl/ptu_ram.sv
// ----------------------------------------------------------------------------
// ptu_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module ptu_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 32,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    rdata_o <= mem_q[raddr_i];
  end

endmodule

>>> rtl/ptu_update.sv
// ----------------------------------------------------------------------------
// ptu_update
// Pipelined per-entry integrator: ages the particle, drops expired ones,
// steps vertical speed and then vertical position with saturation.
// ----------------------------------------------------------------------------
module ptu_update
  import ptu_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               vld_i,
  input  entry_t             entry_i,
  input  logic signed [24:0] gstep_i,
  input  logic        [15:0] dt_i,
  output upd_t               upd_o,
  output logic               busy_o
);

  logic [24:0]        age_sum;
  logic [23:0]        age_new;
  logic               keep;
  logic signed [32:0] vsum;
  entry_t             s1_d;

  logic               s1_vld_q;
  entry_t             s1_q;
  logic signed [48:0] prod;
  logic               s2_vld_q;
  entry_t             s2_q;
  logic signed [48:0] s2_prod_q;
  logic signed [33:0] ysum;

  // stage 1: age, expiry check, speed step
  always_comb begin
    age_sum = {1'b0, entry_i.age} + {9'd0, dt_i};
    age_new = age_sum[24] ? 24'hff_ffff : age_sum[23:0];
    keep    = (age_new <= entry_i.life);
    vsum    = {entry_i.speed_y[31], entry_i.speed_y} + {{8{gstep_i[24]}}, gstep_i};
    s1_d         = entry_i;
    s1_d.age     = age_new;
    s1_d.speed_y = sat33(vsum);
  end

  // stage 2: speed times dt
  assign prod = {{17{s1_q.speed_y[31]}}, s1_q.speed_y} * $signed({33'd0, dt_i});

  // stage 3: position step, floor shift by 16
  assign ysum = {{2{s2_q.pos_y[31]}}, s2_q.pos_y}
              + {s2_prod_q[48], s2_prod_q[48:16]};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
      s2_vld_q <= 1'b0;
    end else begin
      s1_vld_q <= vld_i && keep;
      s2_vld_q <= s1_vld_q;
    end
  end

  // stage payload
  always_ff @(posedge clk_i) begin
    s1_q      <= s1_d;
    s2_q      <= s1_q;
    s2_prod_q <= prod;
  end

  // write-back result
  always_comb begin
    upd_o.vld         = s2_vld_q;
    upd_o.entry       = s2_q;
    upd_o.entry.pos_y = sat34(ysum);
  end

  assign busy_o = s1_vld_q || s2_vld_q;

endmodule

>>> rtl/particle_table_update_top.sv
// ----------------------------------------------------------------------------
// particle_table_update_top
// Ordered particle table with Euler integration of vertical motion.
// ----------------------------------------------------------------------------
// A spawn transaction's single result is ready in the output register the next
// cycle. A tick runs two passes over the table memory through its one read
// port: an update pass that ages, drops, integrates and compacts every entry,
// then a report pass that reads back each survivor and presents it; a tick
// that leaves no particle ends with one status result after the update pass.
// The next transaction is taken once the sequencer is idle and the output
// register is free or being emptied. Configuration writes are always taken
// and act at once, so write them only while no transaction is in flight.
// ----------------------------------------------------------------------------
module particle_table_update_top
  import ptu_pkg::*;
#(
  parameter int unsigned PARTICLES = 32
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  // configuration write channel
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic               cfg_index_i,
  input  logic        [23:0] cfg_data_i,
  // input channel
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic               op_i,
  input  logic signed [31:0] spawn_x_i,
  input  logic signed [31:0] spawn_y_i,
  input  logic signed [31:0] spawn_z_i,
  input  logic        [23:0] lifetime_i,
  input  logic        [15:0] sprite_size_i,
  input  logic        [15:0] delta_time_i,
  // output channel
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic        [1:0]  status_o,
  output logic signed [31:0] out_x_o,
  output logic signed [31:0] out_y_o,
  output logic signed [31:0] out_z_o,
  output logic        [15:0] out_size_o,
  output logic [CntW-1:0]    live_count_o,
  output logic               last_o
);

  localparam int unsigned AW = (PARTICLES > 1) ? $clog2(PARTICLES) : 1;
  localparam logic [CntW-1:0] MaxCnt = CntW'(PARTICLES);

  state_e             state_q;
  logic [CntW-1:0]    cnt_q;
  logic [CntW-1:0]    idx_q;
  logic [CntW-1:0]    rd_idx_q;
  logic               rd_vld_q;
  logic [CntW-1:0]    w_q;
  logic [15:0]        dt_q;
  logic signed [24:0] gstep_q;
  logic signed [23:0] grav_q;
  logic signed [23:0] launch_q;

  logic               out_vld_q;
  status_e            status_q;
  logic signed [31:0] ox_q;
  logic signed [31:0] oy_q;
  logic signed [31:0] oz_q;
  logic        [15:0] osize_q;
  logic [CntW-1:0]    olive_q;
  logic               olast_q;

  logic               adv;
  logic               in_acc;
  logic               spawn_ok;
  logic               full;
  logic               upd_done;
  logic               rep_last;
  logic               out_load;
  logic signed [40:0] gprod;

  logic               ram_we;
  logic [AW-1:0]      ram_waddr;
  entry_t             ram_wdata;
  logic [AW-1:0]      ram_raddr;
  entry_t             ram_rdata;
  entry_t             spawn_entry;

  upd_t               upd;
  logic               upd_busy;

  // handshakes
  assign cfg_ready_o = 1'b1;
  assign adv         = !out_vld_q || !out_stall_i;
  assign in_stall_o  = !((state_q == S_IDLE) && adv);
  assign in_acc      = in_valid_i && !in_stall_o;
  assign full        = (cnt_q >= MaxCnt);
  assign spawn_ok    = in_acc && (op_i == OP_SPAWN) && !full;
  assign upd_done    = (idx_q == cnt_q) && !rd_vld_q && !upd_busy;
  assign rep_last    = rd_vld_q && (rd_idx_q == (cnt_q - CntW'(1)));

  // a new result enters the output register
  assign out_load = ((state_q == S_IDLE) && in_acc && (op_i == OP_SPAWN))
                 || ((state_q == S_REP) && adv && rd_vld_q)
                 || ((state_q == S_NONE) && adv);

  // gravity step per tick, floor of product shifted by 16
  assign gprod = $signed({{17{grav_q[23]}}, grav_q}) * $signed({25'd0, dt_q});

  // new entry built from a spawn transaction
  always_comb begin
    spawn_entry.pos_x   = spawn_x_i;
    spawn_entry.pos_y   = spawn_y_i;
    spawn_entry.pos_z   = spawn_z_i;
    spawn_entry.speed_y = {{8{launch_q[23]}}, launch_q};
    spawn_entry.age     = 24'd0;
    spawn_entry.life    = lifetime_i;
    spawn_entry.size    = sprite_size_i;
  end

  // memory ports: spawn append or compacting write-back; held read while stalled
  assign ram_we    = spawn_ok || upd.vld;
  assign ram_waddr = spawn_ok ? cnt_q[AW-1:0] : w_q[AW-1:0];
  assign ram_wdata = spawn_ok ? spawn_entry : upd.entry;
  assign ram_raddr = ((state_q == S_REP) && !adv) ? rd_idx_q[AW-1:0] : idx_q[AW-1:0];

  ptu_ram #(
    .WIDTH ($bits(entry_t)),
    .DEPTH (PARTICLES)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  ptu_update u_update (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .vld_i   (rd_vld_q && (state_q == S_UPD)),
    .entry_i (ram_rdata),
    .gstep_i (gstep_q),
    .dt_i    (dt_q),
    .upd_o   (upd),
    .busy_o  (upd_busy)
  );

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      grav_q   <= -24'sd314573;
      launch_q <= 24'sd229376;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_GRAVITY: grav_q   <= cfg_data_i;
        CFG_LAUNCH:  launch_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // output valid: set on load, cleared when taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (out_load) begin
      out_vld_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_vld_q <= 1'b0;
    end
  end

  // sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      cnt_q     <= '0;
      idx_q     <= '0;
      rd_idx_q  <= '0;
      rd_vld_q  <= 1'b0;
      w_q       <= '0;
    end else begin
      case (state_q)
        S_IDLE: begin
          if (in_acc) begin
            if (op_i == OP_SPAWN) begin
              if (!full) begin
                cnt_q <= cnt_q + CntW'(1);
              end
            end else begin
              idx_q    <= '0;
              w_q      <= '0;
              rd_vld_q <= 1'b0;
              state_q  <= S_UPD;
            end
          end
        end
        S_UPD: begin
          if (idx_q < cnt_q) begin
            idx_q    <= idx_q + CntW'(1);
            rd_vld_q <= 1'b1;
          end else begin
            rd_vld_q <= 1'b0;
          end
          if (upd.vld) begin
            w_q <= w_q + CntW'(1);
          end
          if (upd_done) begin
            cnt_q    <= w_q;
            idx_q    <= '0;
            rd_vld_q <= 1'b0;
            state_q  <= (w_q == '0) ? S_NONE : S_REP;
          end
        end
        S_REP: begin
          if (adv) begin
            if (rep_last) begin
              rd_vld_q <= 1'b0;
              state_q  <= S_IDLE;
            end else if (idx_q < cnt_q) begin
              rd_vld_q <= 1'b1;
              rd_idx_q <= idx_q;
              idx_q    <= idx_q + CntW'(1);
            end else begin
              rd_vld_q <= 1'b0;
            end
          end
        end
        S_NONE: begin
          if (adv) begin
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  // tick payload registers
  always_ff @(posedge clk_i) begin
    if (in_acc && (op_i == OP_TICK)) begin
      dt_q <= delta_time_i;
    end
    gstep_q <= gprod[40:16];
  end

  // output register load
  always_ff @(posedge clk_i) begin
    if ((state_q == S_IDLE) && in_acc && (op_i == OP_SPAWN)) begin
      status_q <= full ? ST_FULL : ST_SPAWNED;
      ox_q     <= full ? 32'sd0 : spawn_x_i;
      oy_q     <= full ? 32'sd0 : spawn_y_i;
      oz_q     <= full ? 32'sd0 : spawn_z_i;
      osize_q  <= full ? 16'd0 : sprite_size_i;
      olive_q  <= full ? cnt_q : cnt_q + CntW'(1);
      olast_q  <= 1'b1;
    end else if ((state_q == S_REP) && adv && rd_vld_q) begin
      status_q <= ST_REPORT;
      ox_q     <= ram_rdata.pos_x;
      oy_q     <= ram_rdata.pos_y;
      oz_q     <= ram_rdata.pos_z;
      osize_q  <= ram_rdata.size;
      olive_q  <= cnt_q;
      olast_q  <= rep_last;
    end else if ((state_q == S_NONE) && adv) begin
      status_q <= ST_EMPTY;
      ox_q     <= 32'sd0;
      oy_q     <= 32'sd0;
      oz_q     <= 32'sd0;
      osize_q  <= 16'd0;
      olive_q  <= '0;
      olast_q  <= 1'b1;
    end
  end

  assign out_valid_o  = out_vld_q;
  assign status_o     = status_q;
  assign out_x_o      = ox_q;
  assign out_y_o      = oy_q;
  assign out_z_o      = oz_q;
  assign out_size_o   = osize_q;
  assign live_count_o = olive_q;
  assign last_o       = olast_q;

endmodule

>>> test/tb_particle_table_update_top.sv
// ----------------------------------------------------------------------------
// tb_particle_table_update_top
// Self-checking bench for the particle table: spawns, ticks and register
// writes go in through the handshake ports, and a cycle-free table predictor
// works out every expected report. Both ports idle and stall at random.
// ----------------------------------------------------------------------------
module tb_particle_table_update_top
  import ptu_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned PARTICLES    = 32;
  localparam int unsigned SETTLE_TICKS = 12;
  localparam int unsigned PRINT_CAP    = 50;

  // one input transaction
  typedef struct {
    logic               op;
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] z;
    logic        [23:0] life;
    logic        [15:0] size;
    logic        [15:0] dt;
  } particle_item_t;

  // one expected output transaction
  typedef struct {
    status_e            status;
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] z;
    logic        [15:0] size;
    logic [CntW-1:0]    live;
    logic               last;
  } particle_report_t;

  logic               clk_i;
  logic               rst_ni;
  logic               cfg_valid_i;
  logic               cfg_ready_o;
  logic               cfg_index_i;
  logic        [23:0] cfg_data_i;
  logic               in_valid_i;
  logic               in_stall_o;
  logic               op_i;
  logic signed [31:0] spawn_x_i;
  logic signed [31:0] spawn_y_i;
  logic signed [31:0] spawn_z_i;
  logic        [23:0] lifetime_i;
  logic        [15:0] sprite_size_i;
  logic        [15:0] delta_time_i;
  logic               out_valid_o;
  logic               out_stall_i;
  logic        [1:0]  status_o;
  logic signed [31:0] out_x_o;
  logic signed [31:0] out_y_o;
  logic signed [31:0] out_z_o;
  logic        [15:0] out_size_o;
  logic [CntW-1:0]    live_count_o;
  logic               last_o;

  // predicted table contents and registers
  logic signed [31:0] tab_x    [PARTICLES];
  logic signed [31:0] tab_y    [PARTICLES];
  logic signed [31:0] tab_z    [PARTICLES];
  logic signed [31:0] tab_vy   [PARTICLES];
  logic        [23:0] tab_age  [PARTICLES];
  logic        [23:0] tab_life [PARTICLES];
  logic        [15:0] tab_size [PARTICLES];
  int unsigned        tab_live;
  logic signed [23:0] gravity_reg;
  logic signed [23:0] launch_reg;

  particle_report_t pending_reports[$];
  particle_report_t head_report;
  int unsigned      errors;
  bit               quiet;

  particle_table_update_top #(
    .PARTICLES(PARTICLES)
  ) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .op_i         (op_i),
    .spawn_x_i    (spawn_x_i),
    .spawn_y_i    (spawn_y_i),
    .spawn_z_i    (spawn_z_i),
    .lifetime_i   (lifetime_i),
    .sprite_size_i(sprite_size_i),
    .delta_time_i (delta_time_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .status_o     (status_o),
    .out_x_o      (out_x_o),
    .out_y_o      (out_y_o),
    .out_z_o      (out_z_o),
    .out_size_o   (out_size_o),
    .live_count_o (live_count_o),
    .last_o       (last_o)
  );

  // clock
  initial clk_i = 1'b0;
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // mismatch reporting
  task automatic report_mismatch(input string what, input longint got, input longint want);
    if (errors < PRINT_CAP) begin
      $display("mismatch at %0t: %s got %0d expected %0d", $realtime, what, got, want);
    end
    errors++;
  endtask

  // clamp to signed 32 bits
  function automatic logic signed [31:0] clamp32(input longint v);
    if (v > 64'sd2147483647) return 32'sh7fff_ffff;
    if (v < -64'sd2147483648) return 32'sh8000_0000;
    return v[31:0];
  endfunction

  function automatic void queue_report(input status_e s, input logic signed [31:0] x,
                                       input logic signed [31:0] y,
                                       input logic signed [31:0] z,
                                       input logic [15:0] size, input logic last);
    particle_report_t r;
    r.status = s;
    r.x      = x;
    r.y      = y;
    r.z      = z;
    r.size   = size;
    r.live   = tab_live[CntW-1:0];
    r.last   = last;
    pending_reports.push_back(r);
  endfunction

  // table predictor: spawn appends, tick ages, drops, integrates and compacts
  function automatic void predict_table(input particle_item_t it);
    int unsigned kept;
    int unsigned age_sum;
    longint      dt;
    logic signed [31:0] new_vy;
    logic signed [31:0] new_y;
    if (it.op == OP_SPAWN) begin
      if (tab_live >= PARTICLES) begin
        queue_report(ST_FULL, '0, '0, '0, '0, 1'b1);
      end else begin
        tab_x[tab_live]    = it.x;
        tab_y[tab_live]    = it.y;
        tab_z[tab_live]    = it.z;
        tab_vy[tab_live]   = 32'(launch_reg);
        tab_age[tab_live]  = '0;
        tab_life[tab_live] = it.life;
        tab_size[tab_live] = it.size;
        tab_live++;
        queue_report(ST_SPAWNED, it.x, it.y, it.z, it.size, 1'b1);
      end
    end else begin
      dt   = longint'({1'b0, it.dt});
      kept = 0;
      for (int i = 0; i < tab_live; i++) begin
        age_sum = tab_age[i] + it.dt;
        if (age_sum > 32'hff_ffff) age_sum = 32'hff_ffff;
        if (age_sum > tab_life[i]) continue;
        new_vy = clamp32(longint'(tab_vy[i]) + ((longint'(gravity_reg) * dt) >>> 16));
        new_y  = clamp32(longint'(tab_y[i]) + ((longint'(new_vy) * dt) >>> 16));
        tab_x[kept]    = tab_x[i];
        tab_y[kept]    = new_y;
        tab_z[kept]    = tab_z[i];
        tab_vy[kept]   = new_vy;
        tab_age[kept]  = age_sum[23:0];
        tab_life[kept] = tab_life[i];
        tab_size[kept] = tab_size[i];
        kept++;
      end
      tab_live = kept;
      if (kept == 0) begin
        queue_report(ST_EMPTY, '0, '0, '0, '0, 1'b1);
      end else begin
        for (int i = 0; i < kept; i++) begin
          queue_report(ST_REPORT, tab_x[i], tab_y[i], tab_z[i], tab_size[i],
                       (i + 1 == kept));
        end
      end
    end
  endfunction

  // output stall, raised at random with an 8 percent chance unless in a quiet stretch
  always @(posedge clk_i) begin
    out_stall_i <= !quiet && ($urandom_range(99) < 8);
  end

  // compare each accepted output transaction with the oldest prediction
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_reports.size() == 0) begin
        report_mismatch("unexpected result, status", status_o, -1);
      end else begin
        head_report = pending_reports.pop_front();
        if (status_o !== head_report.status)
          report_mismatch("status", status_o, head_report.status);
        if (out_x_o !== head_report.x) report_mismatch("out_x", out_x_o, head_report.x);
        if (out_y_o !== head_report.y) report_mismatch("out_y", out_y_o, head_report.y);
        if (out_z_o !== head_report.z) report_mismatch("out_z", out_z_o, head_report.z);
        if (out_size_o !== head_report.size)
          report_mismatch("out_size", out_size_o, head_report.size);
        if (live_count_o !== head_report.live)
          report_mismatch("live_count", live_count_o, head_report.live);
        if (last_o !== head_report.last)
          report_mismatch("last", last_o, head_report.last);
      end
    end
  end

  // send one input transaction and predict its results once taken
  task automatic send_item(input particle_item_t it);
    while (!quiet && $urandom_range(99) < 8) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    op_i          <= it.op;
    spawn_x_i     <= it.x;
    spawn_y_i     <= it.y;
    spawn_z_i     <= it.z;
    lifetime_i    <= it.life;
    sprite_size_i <= it.size;
    delta_time_i  <= it.dt;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    predict_table(it);
  endtask

  // drop valid and wait until every predicted result has come out
  task automatic settle();
    in_valid_i <= 1'b0;
    while (pending_reports.size() != 0) @(posedge clk_i);
    repeat (SETTLE_TICKS) @(posedge clk_i);
  endtask

  // write both registers, only while the block is idle
  task automatic set_config(input logic signed [23:0] gravity,
                            input logic signed [23:0] launch);
    settle();
    cfg_valid_i <= 1'b1;
    cfg_index_i <= CFG_GRAVITY;
    cfg_data_i  <= gravity;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    gravity_reg = gravity;
    cfg_index_i <= CFG_LAUNCH;
    cfg_data_i  <= launch;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    launch_reg = launch;
    cfg_valid_i <= 1'b0;
  endtask

  function automatic particle_item_t make_spawn(input logic signed [31:0] x,
                                                input logic signed [31:0] y,
                                                input logic signed [31:0] z,
                                                input logic [23:0] life,
                                                input logic [15:0] size);
    particle_item_t it;
    it.op   = OP_SPAWN;
    it.x    = x;
    it.y    = y;
    it.z    = z;
    it.life = life;
    it.size = size;
    it.dt   = 16'($urandom);
    return it;
  endfunction

  function automatic particle_item_t make_tick(input logic [15:0] dt);
    particle_item_t it;
    it.op   = OP_TICK;
    it.x    = $urandom;
    it.y    = $urandom;
    it.z    = $urandom;
    it.life = 24'($urandom);
    it.size = 16'($urandom);
    it.dt   = dt;
    return it;
  endfunction

  // mostly short lifetimes, a few long ones over the full field
  function automatic logic [23:0] pick_life();
    if ($urandom_range(99) < 6) return 24'($urandom);
    return 24'($urandom_range(0, 24'h3_ffff));
  endfunction

  function automatic particle_item_t random_spawn();
    return make_spawn($urandom, $urandom, $urandom, pick_life(), 16'($urandom));
  endfunction

  // tick on an empty table, spawns at the field extremes, ticks at dt edges
  task automatic test_directed_edges();
    send_item(make_tick(16'h1234));
    send_item(make_spawn(32'sh7fff_ffff, 32'sh8000_0000, 32'sh0, 24'h0, 16'hffff));
    send_item(make_spawn(32'sh8000_0000, 32'sh7fff_ffff, -32'sd1, 24'hff_ffff, 16'h0));
    send_item(make_spawn(32'sh1, 32'sh0, 32'sh0001_0000, 24'h00_8000, 16'h0100));
    // zero dt keeps even a zero lifetime alive
    send_item(make_tick(16'h0000));
    // first particle dies, the rest move down in order
    send_item(make_tick(16'h0001));
    send_item(make_tick(16'hffff));
    send_item(make_tick(16'hffff));
  endtask

  // position clamping in both directions with extreme registers
  task automatic test_position_clamp();
    set_config(24'sh7f_ffff, 24'sh7f_ffff);
    send_item(make_spawn(32'sh0, 32'sh7fff_0000, 32'sh0, 24'h04_0000, 16'h1234));
    send_item(make_tick(16'hffff));
    send_item(make_tick(16'hffff));
    set_config(-24'sd8388608, -24'sd8388608);
    send_item(make_spawn(32'sh0, 32'sh8001_0000, 32'sh0, 24'h04_0000, 16'h4321));
    send_item(make_tick(16'hffff));
    send_item(make_tick(16'h8000));
    send_item(make_tick(16'hffff));
  endtask

  // fill the table past its size, then report the whole table
  task automatic test_table_full();
    set_config(24'($urandom), 24'($urandom));
    while (tab_live < PARTICLES) begin
      send_item(make_spawn($urandom, $urandom, $urandom,
                           24'($urandom_range(0, 24'h7_ffff)), 16'($urandom)));
    end
    send_item(random_spawn());
    send_item(random_spawn());
    send_item(make_tick(16'h0000));
    send_item(make_tick(16'hffff));
  endtask

  // long run of large ticks under extreme registers: positions clamp, ages pile up
  task automatic test_saturation();
    set_config(-24'sd8388608, 24'sh7f_ffff);
    send_item(make_spawn($urandom, $urandom, $urandom, 24'hff_ffff, 16'($urandom)));
    for (int n = 0; n < 200; n++) begin
      if ($urandom_range(99) < 20) begin
        send_item(random_spawn());
      end else begin
        send_item(make_tick(16'($urandom_range(16'hf000, 16'hffff))));
      end
    end
  endtask

  // mixed spawns and ticks under several register settings
  task automatic test_random_mix();
    for (int n = 0; n < 130; n++) begin
      if (n == 40) set_config(24'sh0, 24'sh0);
      if (n == 90) set_config(24'($urandom), 24'($urandom));
      quiet = (n >= 45 && n < 95);
      if ($urandom_range(99) < 55) begin
        send_item(random_spawn());
      end else if ($urandom_range(3) == 0) begin
        send_item(make_tick(16'($urandom_range(0, 16'h00ff))));
      end else begin
        send_item(make_tick(16'($urandom)));
      end
    end
    quiet = 1'b0;
  endtask

  // stimulus sequence and final verdict
  initial begin
    errors        = 0;
    quiet         = 1'b0;
    tab_live      = 0;
    gravity_reg   = -24'sd314573;
    launch_reg    = 24'sd229376;
    rst_ni        <= 1'b0;
    cfg_valid_i   <= 1'b0;
    cfg_index_i   <= CFG_GRAVITY;
    cfg_data_i    <= '0;
    in_valid_i    <= 1'b0;
    op_i          <= OP_SPAWN;
    spawn_x_i     <= '0;
    spawn_y_i     <= '0;
    spawn_z_i     <= '0;
    lifetime_i    <= '0;
    sprite_size_i <= '0;
    delta_time_i  <= '0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed_edges();
    test_position_clamp();
    test_table_full();
    test_saturation();
    test_random_mix();
    set_config(-24'sd314573, 24'sd229376);

    settle();
    if (pending_reports.size() != 0) begin
      report_mismatch("results never seen", 0, pending_reports.size());
    end
    if (errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  // watchdog
  initial begin
    #10ms;
    $display("status: fail");
    $finish;
  end

endmodule

>>> sim.f
rtl/ptu_pkg.sv
rtl/ptu_ram.sv
rtl/ptu_update.sv
rtl/particle_table_update_top.sv
test/tb_particle_table_update_top.sv
